// File: sv/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg: shared types and constants for the pH dosing pump controller
// Field widths, register indexes, dose bands and settle timing constants.
// ----------------------------------------------------------------------------
package phd_pkg;

    // Timer base: ticks in one second of settle time.
    localparam int unsigned TICKS_PER_SECOND = 1000;

    // Field widths.
    localparam int RAW_W        = 16;
    localparam int GAIN_W       = 18;
    localparam int GAIN_FRAC_W  = 14;
    localparam int OFFSET_W     = 16;
    localparam int TARGET_W     = 14;
    localparam int SECONDS_W    = 12;
    localparam int CAL_W        = 16;
    localparam int ERR_W        = 17;
    localparam int DOSE_W       = 12;
    localparam int SETTLE_W     = 22;
    localparam int CFG_DATA_W   = 18;
    localparam int CFG_INDEX_W  = 3;

    // Products and sums in the calibration path.
    localparam int PROD_W   = RAW_W + GAIN_W;
    localparam int SCALED_W = PROD_W - GAIN_FRAC_W;
    localparam int SUM_W    = SCALED_W + 1;
    localparam int DIFF_W   = CAL_W + 2;

    // Settle wait limit and the settle length after reset (ten seconds).
    localparam logic [SETTLE_W-1:0] SETTLE_MAX = '1;
    localparam longint unsigned SETTLE_RST_FULL = 64'(10) * 64'(TICKS_PER_SECOND);
    localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST =
        (SETTLE_RST_FULL > 64'(SETTLE_MAX)) ? SETTLE_MAX : SETTLE_W'(SETTLE_RST_FULL);

    // Register reset values.
    localparam logic signed [GAIN_W-1:0]   CAL_GAIN_RST   = 18'sd16384;
    localparam logic signed [OFFSET_W-1:0] CAL_OFFSET_RST = 16'sd0;
    localparam logic [TARGET_W-1:0]        TARGET_PH_RST  = 14'd7000;

    // Dose bands: upper error limits (exclusive) and the run times they give.
    localparam logic signed [ERR_W-1:0] BAND_1_LIMIT = 17'sd50;
    localparam logic signed [ERR_W-1:0] BAND_2_LIMIT = 17'sd100;
    localparam logic signed [ERR_W-1:0] BAND_3_LIMIT = 17'sd200;
    localparam logic signed [ERR_W-1:0] BAND_4_LIMIT = 17'sd16000;
    localparam logic [DOSE_W-1:0] DOSE_NONE   = 12'd0;
    localparam logic [DOSE_W-1:0] DOSE_BAND_1 = 12'd500;
    localparam logic [DOSE_W-1:0] DOSE_BAND_2 = 12'd1000;
    localparam logic [DOSE_W-1:0] DOSE_BAND_3 = 12'd2000;
    localparam logic [DOSE_W-1:0] DOSE_BAND_4 = 12'd3000;

    // Calibration saturation limits.
    localparam logic signed [SUM_W-1:0] CAL_SAT_HI = 21'sd32767;
    localparam logic signed [SUM_W-1:0] CAL_SAT_LO = -21'sd32768;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CAL_GAIN       = 3'd0,
        REG_CAL_OFFSET     = 3'd1,
        REG_TARGET_PH      = 3'd2,
        REG_DOSE_MODE      = 3'd3,
        REG_SETTLE_SECONDS = 3'd4,
        REG_DOSING_ENABLE  = 3'd5
    } phd_reg_t;

    // Dose direction.
    typedef enum logic {
        MODE_ACID   = 1'b0,
        MODE_ALKALI = 1'b1
    } phd_mode_t;

    // Calibration settings seen by the decision logic.
    typedef struct packed {
        logic signed [GAIN_W-1:0]   cal_gain;
        logic signed [OFFSET_W-1:0] cal_offset;
        logic [TARGET_W-1:0]        target_ph;
        phd_mode_t                  dose_mode;
    } phd_cfg_t;

    // Outcome of one dosing decision.
    typedef struct packed {
        logic signed [CAL_W-1:0] cal;
        logic signed [ERR_W-1:0] err;
        logic [DOSE_W-1:0]       dose;
    } phd_calc_t;

endpackage

// File: sv/phd_calc.sv
// ----------------------------------------------------------------------------
// phd_calc: dosing decision for one pH sample
// Calibrates the raw reading, forms the error and picks the pump run time.
// ----------------------------------------------------------------------------
module phd_calc (
    input  logic signed [phd_pkg::RAW_W-1:0] raw_reading,
    input  phd_pkg::phd_cfg_t                cfg,
    output phd_pkg::phd_calc_t               result
);
    import phd_pkg::*;

    logic signed [PROD_W-1:0]   prod;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [SUM_W-1:0]    sum;
    logic signed [CAL_W-1:0]    cal;
    logic signed [DIFF_W-1:0]   target_s;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [ERR_W-1:0]    err;
    logic [DOSE_W-1:0]          dose;

    // The arithmetic shift of the product rounds toward minus infinity.
    assign prod   = PROD_W'(raw_reading) * PROD_W'(cfg.cal_gain);
    assign scaled = prod[PROD_W-1:GAIN_FRAC_W];
    assign sum    = SUM_W'(scaled) + SUM_W'(cfg.cal_offset);

    always_comb
    begin
        priority if (sum > CAL_SAT_HI)
        begin
            cal = CAL_SAT_HI[CAL_W-1:0];
        end
        else if (sum < CAL_SAT_LO)
        begin
            cal = CAL_SAT_LO[CAL_W-1:0];
        end
        else
        begin
            cal = sum[CAL_W-1:0];
        end
    end

    assign target_s = $signed({{(DIFF_W-TARGET_W){1'b0}}, cfg.target_ph});

    always_comb
    begin
        unique case (cfg.dose_mode)
            MODE_ACID:   diff = DIFF_W'(cal) - target_s;
            MODE_ALKALI: diff = target_s - DIFF_W'(cal);
            default:     diff = '0;
        endcase
    end

    // The difference always fits in the error width.
    assign err = diff[ERR_W-1:0];

    always_comb
    begin
        priority if (err < 0)
        begin
            dose = DOSE_NONE;
        end
        else if (err < BAND_1_LIMIT)
        begin
            dose = DOSE_BAND_1;
        end
        else if (err < BAND_2_LIMIT)
        begin
            dose = DOSE_BAND_2;
        end
        else if (err < BAND_3_LIMIT)
        begin
            dose = DOSE_BAND_3;
        end
        else if (err < BAND_4_LIMIT)
        begin
            dose = DOSE_BAND_4;
        end
        else
        begin
            dose = DOSE_NONE;
        end
    end

    assign result.cal  = cal;
    assign result.err  = err;
    assign result.dose = dose;

endmodule

// File: sv/ph_dosing_pump_controller_core.sv
// ----------------------------------------------------------------------------
// ph_dosing_pump_controller_core: pH dosing pump controller
// Takes millisecond ticks and raw pH samples and drives one dosing pump.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction
//  --------  ----------------------------------------  ---------
//  input     in_valid, in_ready, func, raw_reading     sink
//  result    out_valid, out_ready, pump_running,       source
//            sample_used, dose_time_ms, calibrated_ph,
//            ph_error, settling
//  config    cfg_wr_en, cfg_index, cfg_data            sink
//
//  One input transfer can be taken in every cycle in which the result register
//  is free or is being emptied. An item is held in the input register, then
//  the decision logic (one 16x18 multiply, a subtract and the band compares)
//  updates the controller state and loads the result register as it moves on.
//  Reset clears the state and the handshake flags and loads the register
//  defaults; no clearing pass is needed. While the result register waits
//  with out_ready low, an empty input register still takes one item; once it
//  holds one, in_ready is low in that same cycle.
//
module ph_dosing_pump_controller_core (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 func,
    input  logic signed [phd_pkg::RAW_W-1:0]     raw_reading,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 pump_running,
    output logic                                 sample_used,
    output logic [phd_pkg::DOSE_W-1:0]           dose_time_ms,
    output logic signed [phd_pkg::CAL_W-1:0]     calibrated_ph,
    output logic signed [phd_pkg::ERR_W-1:0]     ph_error,
    output logic                                 settling,

    input  logic                                 cfg_wr_en,
    input  logic [phd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [phd_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import phd_pkg::*;

    // Configuration registers. The settle length is kept in ticks, worked out
    // when settle_seconds is written, so the sample path has no multiply by it.
    phd_cfg_t              cfg_reg;
    logic [SETTLE_W-1:0]   settle_ticks_reg;
    logic                  dosing_enable_reg;
    logic [31:0]           settle_product;

    // Input register.
    logic                  s1_valid_reg;
    logic                  s1_func_reg;
    logic signed [RAW_W-1:0] s1_raw_reg;
    logic                  s1_advance;

    // Controller state.
    logic [DOSE_W-1:0]     pump_left_reg, pump_left_next;
    logic                  pump_flag_reg, pump_flag_next;
    logic [SETTLE_W-1:0]   settle_left_reg, settle_left_next;
    logic signed [CAL_W-1:0] last_cal_reg, last_cal_next;
    logic signed [ERR_W-1:0] last_err_reg, last_err_next;
    logic [DOSE_W-1:0]     last_dose_reg, last_dose_next;
    logic                  sample_take;

    // Result register.
    logic                  out_valid_reg;
    logic                  pump_running_reg;
    logic                  sample_used_reg;
    logic [DOSE_W-1:0]     dose_time_reg;
    logic signed [CAL_W-1:0] calibrated_reg;
    logic signed [ERR_W-1:0] ph_error_reg;
    logic                  settling_reg;

    phd_calc_t             calc;

    // ------------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------------
    assign settle_product = 32'(cfg_data[SECONDS_W-1:0]) * 32'(TICKS_PER_SECOND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_gain   <= CAL_GAIN_RST;
            cfg_reg.cal_offset <= CAL_OFFSET_RST;
            cfg_reg.target_ph  <= TARGET_PH_RST;
            cfg_reg.dose_mode  <= MODE_ACID;
            settle_ticks_reg   <= SETTLE_TICKS_RST;
            dosing_enable_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (phd_reg_t'(cfg_index))
                REG_CAL_GAIN:       cfg_reg.cal_gain   <= $signed(cfg_data[GAIN_W-1:0]);
                REG_CAL_OFFSET:     cfg_reg.cal_offset <= $signed(cfg_data[OFFSET_W-1:0]);
                REG_TARGET_PH:      cfg_reg.target_ph  <= cfg_data[TARGET_W-1:0];
                REG_DOSE_MODE:      cfg_reg.dose_mode  <= phd_mode_t'(cfg_data[0]);
                REG_SETTLE_SECONDS:
                begin
                    // Saturate the settle length to the width of its counter.
                    if (settle_product > 32'(SETTLE_MAX))
                    begin
                        settle_ticks_reg <= SETTLE_MAX;
                    end
                    else
                    begin
                        settle_ticks_reg <= settle_product[SETTLE_W-1:0];
                    end
                end
                REG_DOSING_ENABLE:  dosing_enable_reg <= cfg_data[0];
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Input register. It moves on whenever the result register is free or is
    // being emptied in the same cycle.
    // ------------------------------------------------------------------------
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_func_reg <= func;
            s1_raw_reg  <= raw_reading;
        end
    end

    // ------------------------------------------------------------------------
    // Dosing decision and next state.
    // ------------------------------------------------------------------------
    phd_calc u_calc (
        .raw_reading (s1_raw_reg),
        .cfg         (cfg_reg),
        .result      (calc)
    );

    // A sample is used only while dosing is on and no settle wait is running.
    assign sample_take = s1_func_reg && dosing_enable_reg && (settle_left_reg == '0);

    always_comb
    begin
        pump_left_next   = pump_left_reg;
        pump_flag_next   = pump_flag_reg;
        settle_left_next = settle_left_reg;
        last_cal_next    = last_cal_reg;
        last_err_next    = last_err_reg;
        last_dose_next   = last_dose_reg;

        if (!s1_func_reg)
        begin
            // Millisecond tick: both timers count down and the pump stops
            // when its timer runs out.
            if (pump_left_reg != '0)
            begin
                pump_left_next = pump_left_reg - 1'b1;
                if (pump_left_reg == DOSE_W'(1))
                begin
                    pump_flag_next = 1'b0;
                end
            end
            if (settle_left_reg != '0)
            begin
                settle_left_next = settle_left_reg - 1'b1;
            end
        end
        else if (sample_take)
        begin
            // A new dose replaces any run in progress; a zero dose stops it.
            last_cal_next    = calc.cal;
            last_err_next    = calc.err;
            last_dose_next   = calc.dose;
            pump_left_next   = calc.dose;
            pump_flag_next   = (calc.dose != '0);
            settle_left_next = settle_ticks_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pump_left_reg   <= '0;
            pump_flag_reg   <= 1'b0;
            settle_left_reg <= '0;
            last_cal_reg    <= '0;
            last_err_reg    <= '0;
            last_dose_reg   <= '0;
        end
        else if (s1_advance)
        begin
            pump_left_reg   <= pump_left_next;
            pump_flag_reg   <= pump_flag_next;
            settle_left_reg <= settle_left_next;
            last_cal_reg    <= last_cal_next;
            last_err_reg    <= last_err_next;
            last_dose_reg   <= last_dose_next;
        end
    end

    // ------------------------------------------------------------------------
    // Result register. It shows the state as the item left it.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            pump_running_reg <= pump_flag_next;
            sample_used_reg  <= sample_take;
            dose_time_reg    <= last_dose_next;
            calibrated_reg   <= last_cal_next;
            ph_error_reg     <= last_err_next;
            settling_reg     <= (settle_left_next != '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign pump_running  = pump_running_reg;
    assign sample_used   = sample_used_reg;
    assign dose_time_ms  = dose_time_reg;
    assign calibrated_ph = calibrated_reg;
    assign ph_error      = ph_error_reg;
    assign settling      = settling_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
`ifndef ASSERT_OFF
    // The pump is driven exactly while its run timer is nonzero.
    a_pump_flag_matches_timer: assert property (
        @(posedge clk) disable iff (!rst_n)
        pump_flag_reg == (pump_left_reg != '0)
    ) else $error("pump flag out of step with its run timer");

    // A sample that arrives during a settle wait is never used.
    a_no_sample_while_settling: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_advance && s1_func_reg && (settle_left_reg != '0) |=> !sample_used
    ) else $error("sample used while a settle wait was running");

    // A waiting result agrees with the state it was taken from.
    a_result_tracks_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (settling == (settle_left_reg != '0))
                   && (pump_running == pump_flag_reg)
                   && (dose_time_ms == last_dose_reg)
    ) else $error("result register differs from controller state");
`endif

endmodule
